[hdl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define BMPL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Checked at every clock edge, reset included.
`define BMPL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("%m: check failed");

`endif

[hdl/bmpl_pkg.sv]
// Shared widths, reset constant and the request type of the modular multiplier.
package bmpl_pkg;

  localparam int unsigned DigitW       = 10;
  localparam int unsigned ArgW         = 63;
  localparam logic [DigitW-1:0] ModulusReset = 10'd7;

  typedef struct packed {
    logic              start;
    logic [DigitW-1:0] a;
    logic [DigitW-1:0] b;
  } mm_req_t;

endpackage

[hdl/binomial_mod_prime_lucas_unit.sv]
// Binomial coefficient modulo a prime by Lucas's theorem, iterative datapath.
//
//  channel   direction  handshake                  payload
//  input     in         in_valid_i / in_stall_o    n_value_i, r_value_i
//  result    out        out_valid_o / out_stall_i  binomial_residue_o
//  config    in         modulus_we_i               modulus_i
//
// Per base-p digit: a long division of n and r by p, table reads, and up to
// 22 modular products in the shared multiplier.
// After reset and after each accepted modulus write the factorial table is
// rebuilt, during which input is stalled.
// One item at a time; a finished result waits in the output register.
module binomial_mod_prime_lucas_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              modulus_we_i,
  input  logic [bmpl_pkg::DigitW-1:0]       modulus_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bmpl_pkg::ArgW-1:0]         n_value_i,
  input  logic [bmpl_pkg::ArgW-1:0]         r_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bmpl_pkg::DigitW-1:0]       binomial_residue_o
);
  import bmpl_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  typedef enum logic [18:0] {
    S_IDLE        = 19'd1,
    S_BUILD_START = 19'd2,
    S_BUILD_GO    = 19'd4,
    S_BUILD_WAIT  = 19'd8,
    S_LOOP        = 19'd16,
    S_DIV         = 19'd32,
    S_CMP         = 19'd64,
    S_RD1         = 19'd128,
    S_RD2         = 19'd256,
    S_BOT_WAIT    = 19'd512,
    S_POW         = 19'd1024,
    S_PMUL_WAIT   = 19'd2048,
    S_PSQ         = 19'd4096,
    S_PSQ_WAIT    = 19'd8192,
    S_TOP         = 19'd16384,
    S_TERM_WAIT   = 19'd32768,
    S_ACC         = 19'd65536,
    S_ACC_WAIT    = 19'd131072,
    S_DONE        = 19'd262144
  } state_e;

  state_e            state_q;
  logic [DigitW-1:0] modulus_q;
  logic [ArgW-1:0]   n_q, r_q;
  logic [DigitW-1:0] remn_q, remr_q;
  logic [5:0]        cnt_q;
  logic [DigitW-1:0] acc_q, tmp_q, base_q, pres_q, exp_q, fac_q, bj_q;
  logic [AW-1:0]     bi_q;
  logic              out_valid_q;
  logic [DigitW-1:0] out_data_q;

  logic [DigitW-1:0] mem [TABLE_DEPTH];
  logic [DigitW-1:0] rd_data_q;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [DigitW-1:0] wr_data;

  mm_req_t           mm_req;
  logic              mm_done;
  logic [DigitW-1:0] mm_res;

  logic              cfg_ok;
  logic [DigitW:0]   rn2, rr2;
  logic              gen, ger;
  logic [DigitW-1:0] bj_inc;

  assign cfg_ok = modulus_we_i && (modulus_i >= 10'd2) &&
                  (32'(modulus_i) <= 32'(TABLE_DEPTH));

  // One quotient bit of n and of r per cycle.
  assign rn2 = {remn_q, n_q[ArgW-1]};
  assign rr2 = {remr_q, r_q[ArgW-1]};
  assign gen = rn2 >= {1'b0, modulus_q};
  assign ger = rr2 >= {1'b0, modulus_q};

  assign bj_inc = bj_q + 1'b1;

  always_comb begin
    mm_req = '0;
    case (state_q)
      S_BUILD_GO: begin
        mm_req = '{start: 1'b1, a: fac_q, b: bj_q};
      end
      S_RD2: begin
        mm_req = '{start: 1'b1, a: tmp_q, b: rd_data_q};
      end
      S_POW: begin
        if (exp_q != '0 && exp_q[0]) begin
          mm_req = '{start: 1'b1, a: pres_q, b: base_q};
        end
      end
      S_PSQ: begin
        mm_req = '{start: 1'b1, a: base_q, b: base_q};
      end
      S_TOP: begin
        mm_req = '{start: 1'b1, a: rd_data_q, b: pres_q};
      end
      S_ACC: begin
        mm_req = '{start: 1'b1, a: acc_q, b: tmp_q};
      end
      default: begin
        mm_req = '0;
      end
    endcase
  end

  always_comb begin
    case (state_q)
      S_CMP:   rd_addr = AW'(remr_q);
      S_RD1:   rd_addr = AW'(remn_q - remr_q);
      default: rd_addr = AW'(remn_q);
    endcase
    wr_en   = 1'b0;
    wr_addr = bi_q;
    wr_data = mm_res;
    if (state_q == S_BUILD_START) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = DigitW'(1);
    end else if (state_q == S_BUILD_WAIT && mm_done) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  bmpl_modmul u_modmul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mm_req),
    .modulus_i (modulus_q),
    .done_o    (mm_done),
    .result_o  (mm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_BUILD_START;
      modulus_q   <= ModulusReset;
      out_valid_q <= 1'b0;
    end else begin
      // In the done state the output register is handled below.
      if (out_valid_q && !out_stall_i && !(state_q == S_DONE && !cfg_ok)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_ok) begin
        modulus_q <= modulus_i;
        state_q   <= S_BUILD_START;
      end else begin
        case (state_q)
          S_IDLE:        if (in_valid_i) state_q <= S_LOOP;
          S_BUILD_START: state_q <= S_BUILD_GO;
          S_BUILD_GO:    state_q <= S_BUILD_WAIT;
          S_BUILD_WAIT: begin
            if (mm_done) begin
              state_q <= (bi_q == AW'(TABLE_DEPTH - 1)) ? S_IDLE : S_BUILD_GO;
            end
          end
          S_LOOP: begin
            state_q <= (n_q == '0 && r_q == '0) ? S_DONE : S_DIV;
          end
          S_DIV:         if (cnt_q == '0) state_q <= S_CMP;
          S_CMP:         state_q <= (remr_q > remn_q) ? S_DONE : S_RD1;
          S_RD1:         state_q <= S_RD2;
          S_RD2:         state_q <= S_BOT_WAIT;
          S_BOT_WAIT:    if (mm_done) state_q <= S_POW;
          S_POW: begin
            if (exp_q == '0) begin
              state_q <= S_TOP;
            end else if (exp_q[0]) begin
              state_q <= S_PMUL_WAIT;
            end else begin
              state_q <= S_PSQ;
            end
          end
          S_PMUL_WAIT:   if (mm_done) state_q <= S_PSQ;
          S_PSQ:         state_q <= S_PSQ_WAIT;
          S_PSQ_WAIT:    if (mm_done) state_q <= S_POW;
          S_TOP:         state_q <= S_TERM_WAIT;
          S_TERM_WAIT:   if (mm_done) state_q <= S_ACC;
          S_ACC:         state_q <= S_ACC_WAIT;
          S_ACC_WAIT:    if (mm_done) state_q <= S_LOOP;
          S_DONE: begin
            if (!out_valid_q || !out_stall_i) begin
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end
          default:       state_q <= S_BUILD_START;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        n_q   <= n_value_i;
        r_q   <= r_value_i;
        acc_q <= DigitW'(1);
      end
      S_BUILD_START: begin
        fac_q <= DigitW'(1);
        bi_q  <= AW'(1);
        bj_q  <= DigitW'(1);
      end
      S_BUILD_WAIT: begin
        if (mm_done) begin
          fac_q <= mm_res;
          bi_q  <= bi_q + 1'b1;
          bj_q  <= (bj_inc == modulus_q) ? '0 : bj_inc;
        end
      end
      S_LOOP: begin
        remn_q <= '0;
        remr_q <= '0;
        cnt_q  <= 6'(ArgW - 1);
      end
      S_DIV: begin
        remn_q <= gen ? DigitW'(rn2 - {1'b0, modulus_q}) : DigitW'(rn2);
        remr_q <= ger ? DigitW'(rr2 - {1'b0, modulus_q}) : DigitW'(rr2);
        n_q    <= {n_q[ArgW-2:0], gen};
        r_q    <= {r_q[ArgW-2:0], ger};
        cnt_q  <= cnt_q - 1'b1;
      end
      S_CMP: begin
        // A lower digit above the upper digit makes the whole product zero.
        if (remr_q > remn_q) begin
          acc_q <= '0;
        end
      end
      S_RD1: begin
        tmp_q <= rd_data_q;
      end
      S_BOT_WAIT: begin
        if (mm_done) begin
          base_q <= mm_res;
          pres_q <= DigitW'(1);
          exp_q  <= modulus_q - 10'd2;
        end
      end
      S_PMUL_WAIT: begin
        if (mm_done) pres_q <= mm_res;
      end
      S_PSQ_WAIT: begin
        if (mm_done) begin
          base_q <= mm_res;
          exp_q  <= exp_q >> 1;
        end
      end
      S_TERM_WAIT: begin
        if (mm_done) tmp_q <= mm_res;
      end
      S_ACC_WAIT: begin
        if (mm_done) acc_q <= mm_res;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) out_data_q <= acc_q;
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign binomial_residue_o = out_data_q;

endmodule

[hdl/bmpl_modmul.sv]
// Shift-and-add modular multiplier, one bit of the first operand per cycle.
module bmpl_modmul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bmpl_pkg::mm_req_t               req_i,
  input  logic [bmpl_pkg::DigitW-1:0]     modulus_i,
  output logic                            done_o,
  output logic [bmpl_pkg::DigitW-1:0]     result_o
);
  import bmpl_pkg::*;

  localparam int unsigned CntW = $clog2(DigitW + 1);

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [DigitW-1:0] acc_q, a_q, b_q;
  logic [DigitW+1:0] sum, p1, p2;
  logic [DigitW-1:0] acc_d;

  // The second operand must already be below the modulus, so the doubled
  // accumulator plus it stays below three times the modulus.
  always_comb begin
    p1  = {2'b00, modulus_i};
    p2  = {1'b0, modulus_i, 1'b0};
    sum = {1'b0, acc_q, 1'b0} + (a_q[DigitW-1] ? {2'b00, b_q} : '0);
    if (sum >= p2) begin
      acc_d = DigitW'(sum - p2);
    end else if (sum >= p1) begin
      acc_d = DigitW'(sum - p1);
    end else begin
      acc_d = DigitW'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DigitW);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
    end else if (busy_q && cnt_q != '0) begin
      acc_q <= acc_d;
      a_q   <= {a_q[DigitW-2:0], 1'b0};
    end
  end

  assign done_o   = busy_q && (cnt_q == '0);
  assign result_o = acc_q;

endmodule

[hdl/bmpl_checker.sv]
// Port-level checks of the binomial unit and the bind that attaches them.
`include "assert_macros.svh"

module bmpl_checker #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         modulus_we_i,
  input logic [bmpl_pkg::DigitW-1:0]  modulus_i,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [bmpl_pkg::ArgW-1:0]    n_value_i,
  input logic [bmpl_pkg::ArgW-1:0]    r_value_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [bmpl_pkg::DigitW-1:0]  binomial_residue_o
);
  import bmpl_pkg::*;

  logic cfg_take;
  logic in_wait;

  assign cfg_take = modulus_we_i && modulus_i >= 10'd2 &&
                    32'(modulus_i) <= 32'(TABLE_DEPTH);
  assign in_wait  = in_valid_i && in_stall_o;

  // Reset holds the unit at the start of the table build, so no beat may enter.
  `BMPL_ASSERT_ALWAYS(a_stall_in_reset, !rst_ni |-> in_stall_o)

  // An accepted beat keeps the unit busy for the following cycle.
  `BMPL_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)

  // A valid modulus write starts a table rebuild, which blocks input.
  `BMPL_ASSERT(a_rebuild_stalls, cfg_take |=> in_stall_o)

  // A stalled input beat stays offered and unchanged.
  `BMPL_ASSERT(a_in_hold, in_wait |=> in_valid_i && $stable({n_value_i, r_value_i}))

  // A result that is held back stays put.
  `BMPL_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(binomial_residue_o))

endmodule

bind binomial_mod_prime_lucas_unit bmpl_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_bmpl_checker (.*);

[dv/tb_binomial_mod_prime_lucas_unit.sv]
// Self-checking testbench for the Lucas binomial residue unit.
module tb_binomial_mod_prime_lucas_unit;
  import bmpl_pkg::*;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned HoldCycles = 8000;
  localparam int unsigned RandPerPhase = 86;

  logic              clk_i;
  logic              rst_ni;
  logic              modulus_we_i;
  logic [DigitW-1:0] modulus_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [ArgW-1:0]   n_value_i;
  logic [ArgW-1:0]   r_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [DigitW-1:0] binomial_residue_o;

  binomial_mod_prime_lucas_unit #(.TABLE_DEPTH(TableDepth)) DUT (
    .clk_i, .rst_ni, .modulus_we_i, .modulus_i, .in_valid_i, .in_stall_o,
    .n_value_i, .r_value_i, .out_valid_o, .out_stall_i, .binomial_residue_o
  );

  typedef struct {
    logic [ArgW-1:0]   n;
    logic [ArgW-1:0]   r;
    bit                known;
    logic [DigitW-1:0] residue;
  } pair_row_t;

  // Directed rows, all at the reset modulus of 7.
  pair_row_t directed_rows[] = '{
    '{63'd0, 63'd0, 1'b1, 10'd1},
    '{'1, '1, 1'b1, 10'd1},
    '{63'd0, '1, 1'b1, 10'd0},
    '{'1, 63'd0, 1'b1, 10'd1},
    '{63'd5, 63'd2, 1'b1, 10'd3},
    '{63'd3, 63'd5, 1'b1, 10'd0},
    '{63'd7, 63'd3, 1'b0, 10'd0},
    '{63'd49, 63'd7, 1'b0, 10'd0},
    '{63'd6, 63'd6, 1'b1, 10'd1},
    '{63'h2AAA_AAAA_AAAA_AAAA, 63'h1555_5555_5555_5555, 1'b0, 10'd0},
    '{63'h4000_0000_0000_0000, 63'd1, 1'b0, 10'd0},
    '{63'd1000, 63'd500, 1'b0, 10'd0}
  };

  // Modulus settings, one per phase; 0 and 1 must be ignored.
  int unsigned modulus_plan[] = '{0, 2, 1, 1021, 3, 1023, 1022, 5, 13, 997, 4, 7};

  longint unsigned   cur_modulus;
  longint unsigned   fact_mod[TableDepth];
  logic [DigitW-1:0] residue_queue[$];
  bit                failed;
  bit                quiet;
  bit                hold_req;

  function automatic void rebuild_factorials();
    longint unsigned acc;
    acc = 1 % cur_modulus;
    fact_mod[0] = acc;
    for (int i = 1; i < TableDepth; i++) begin
      acc = (acc * (i % cur_modulus)) % cur_modulus;
      fact_mod[i] = acc;
    end
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e);
    longint unsigned acc;
    acc = 1 % cur_modulus;
    b = b % cur_modulus;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % cur_modulus;
      b = (b * b) % cur_modulus;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [DigitW-1:0] lucas_residue(logic [ArgW-1:0] n_in,
                                                      logic [ArgW-1:0] r_in);
    longint unsigned n, r, nd, rd, acc, term, denom;
    n = 64'(n_in);
    r = 64'(r_in);
    acc = 1 % cur_modulus;
    while (n != 0 || r != 0) begin
      nd = n % cur_modulus;
      rd = r % cur_modulus;
      if (rd > nd) begin
        term = 0;
      end else begin
        denom = (fact_mod[rd] * fact_mod[nd - rd]) % cur_modulus;
        term = (fact_mod[nd] * pow_mod(denom, cur_modulus - 2)) % cur_modulus;
      end
      acc = (acc * term) % cur_modulus;
      n = n / cur_modulus;
      r = r / cur_modulus;
    end
    return acc[DigitW-1:0];
  endfunction

  // Called at a falling edge; returns at a falling edge after the beat.
  task automatic send_pair(logic [ArgW-1:0] n, logic [ArgW-1:0] r, bit known,
                           logic [DigitW-1:0] residue);
    while (!quiet && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    n_value_i  <= n;
    r_value_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    residue_queue.insert(residue_queue.size(), known ? residue : lucas_residue(n, r));
    @(negedge clk_i);
  endtask

  task automatic write_modulus(int unsigned value);
    in_valid_i <= 1'b0;
    wait (residue_queue.size() == 0);
    @(negedge clk_i);
    modulus_we_i <= 1'b1;
    modulus_i    <= value[DigitW-1:0];
    @(negedge clk_i);
    modulus_we_i <= 1'b0;
    if (value >= 2 && value <= TableDepth) begin
      cur_modulus = 64'(value);
      rebuild_factorials();
    end
  endtask

  function automatic logic [ArgW-1:0] rand_arg(int unsigned w);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[ArgW-1:0] & ((63'd1 << w) - 63'd1);
  endfunction

  task automatic send_random_pair();
    logic [ArgW-1:0] n, r, t;
    int unsigned     w, pick;
    pick = $urandom_range(99);
    // Most pairs stay narrow so that small moduli do not run for many digits.
    w = (pick < 8) ? 63 : $urandom_range(1, 20);
    n = rand_arg(w);
    r = rand_arg($urandom_range(1, w));
    if (pick < 80 && r > n) begin
      t = n; n = r; r = t;
    end else if (pick >= 90 && pick < 95) begin
      n = ArgW'(n - (n % cur_modulus));
    end
    send_pair(n, r, 1'b0, '0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("tb_binomial_mod_prime_lucas_unit: done, errors");
    $finish;
  end

  // Result side stall pattern, with one long hold-off on request.
  initial begin
    out_stall_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (residue_queue.size() == 0) begin
        $display("%0t: unexpected result beat, actual %0d", $time, binomial_residue_o);
        failed = 1'b1;
      end else begin
        if (binomial_residue_o !== residue_queue[0]) begin
          $display("%0t: binomial_residue expected %0d actual %0d", $time,
                   residue_queue[0], binomial_residue_o);
          failed = 1'b1;
        end
        void'(residue_queue.pop_front());
      end
    end
  end

  initial begin
    failed = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    modulus_we_i = 1'b0;
    modulus_i = '0;
    in_valid_i = 1'b0;
    n_value_i = '0;
    r_value_i = '0;
    cur_modulus = 64'(ModulusReset);
    rebuild_factorials();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_pair(directed_rows[i].n, directed_rows[i].r, directed_rows[i].known,
                directed_rows[i].residue);
    for (int k = 0; k < RandPerPhase; k++) send_random_pair();

    foreach (modulus_plan[p]) begin
      write_modulus(modulus_plan[p]);
      quiet = (p == 3);
      // Fill the block up behind a long result stall at the modulus of 1021.
      if (p == 3) hold_req = 1'b1;
      send_pair('1, '1, 1'b0, '0);
      send_pair('1, 63'd0, 1'b0, '0);
      for (int k = 0; k < RandPerPhase; k++) send_random_pair();
      quiet = 1'b0;
    end

    in_valid_i <= 1'b0;
    wait (residue_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    if (failed)
      $display("tb_binomial_mod_prime_lucas_unit: done, errors");
    else
      $display("tb_binomial_mod_prime_lucas_unit: done, clean");
    $finish;
  end

endmodule
